>>> rtl/afd_pkg.sv
// Package for the air quality frame decoder: frame geometry, status codes,
// field widths and the bytewise CRC-8 function. No dependencies.
`timescale 1ns / 1ps

package afd_pkg;

  // Frame geometry
  localparam int unsigned FrameLen = 21;
  localparam int unsigned CrcLen   = 19;
  localparam int unsigned KeepLen  = 13;
  localparam int unsigned CntW     = 5;
  localparam int unsigned KeepIdxW = $clog2(KeepLen);

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first
  localparam logic [7:0] CrcPoly = 8'h31;

  // Decoding constants
  localparam logic [12:0] TempOffset     = 13'sd400;
  localparam logic [7:0]  TypeCodeReset  = 8'h46;
  localparam logic [11:0] TempMaxReset   = 12'd700;
  localparam logic [7:0]  HumMaxReset    = 8'd100;
  localparam logic [7:0]  TempHiMask     = 8'h07;
  localparam logic [7:0]  PmHiMask       = 8'h3f;

  // Configuration register indexes
  localparam logic [1:0] CfgTypeCode = 2'd0;
  localparam logic [1:0] CfgTempMax  = 2'd1;
  localparam logic [1:0] CfgHumMax   = 2'd2;

  // Port widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 104;

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusShort    = 3'd1,
    StatusBadType  = 3'd2,
    StatusBadCrc   = 3'd3,
    StatusBadSum   = 3'd4,
    StatusRange    = 3'd5
  } status_e;

  // Check results captured with the last byte of a frame
  typedef struct packed {
    logic       short_frame;
    logic       crc_bad;
    logic       sum_bad;
    logic [7:0] strength;
  } frame_end_t;

  // One byte through the CRC, eight shift steps
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/air_quality_frame_decoder.sv
// Air quality frame decoder top level: byte stream in, one decoded result per frame.
// Depends on afd_pkg.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: data_byte, signal_strength; tlast
//  m_axis   | out | m_axis_tvalid/tready    | tdata: decoded result (see port)
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle unless the input is stalled. The frame state (count,
// CRC, sum, kept bytes) updates on each byte; the last byte captures the checks
// into a one-entry end stage, which is decoded into the output register once that
// register is free. Input stalls only while the end stage is held behind a full
// output register. Reset restores the register defaults and clears the frame
// counters; kept bytes are not reset.
`timescale 1ns / 1ps

module air_quality_frame_decoder
  import afd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // [7:0] data_byte, [15:8] signal_strength
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] status, [26:3] sensor_id, [38:27] temp_tenths, [46:39] humidity,
  // [60:47] pm25_tenths, [74:61] pm10_tenths, [90:75] co2_ppm,
  // [93:91] battery_bars, [94] battery_low, [102:95] strength_out, [103] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i
);

  // Configuration registers
  logic [7:0]  type_code_q;
  logic [11:0] temp_max_q;
  logic [7:0]  hum_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_code_q <= TypeCodeReset;
      temp_max_q  <= TempMaxReset;
      hum_max_q   <= HumMaxReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTypeCode: type_code_q <= cfg_data_i[7:0];
        CfgTempMax:  temp_max_q  <= cfg_data_i;
        CfgHumMax:   hum_max_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic end_valid_q, end_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, end_adv, in_acc;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign end_adv       = end_valid_q && out_free;
  assign s_axis_tready = !end_valid_q || end_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Frame accumulation
  logic [7:0]      in_byte;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      crc_byte_q, crc_byte_d;
  logic [7:0]      sum_byte_q, sum_byte_d;
  logic [7:0]      keep_q [KeepLen];
  logic            in_frame;

  assign in_byte  = s_axis_tdata[7:0];
  assign in_frame = cnt_q < CntW'(FrameLen);

  always_comb begin
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    sum_d      = sum_q;
    crc_byte_d = crc_byte_q;
    sum_byte_d = sum_byte_q;
    if (in_frame) begin
      if (cnt_q < CntW'(CrcLen)) crc_d = crc8_update(crc_q, in_byte);
      if (cnt_q == CntW'(CrcLen)) crc_byte_d = in_byte;
      if (cnt_q < CntW'(FrameLen - 1)) sum_d = sum_q + in_byte;
      if (cnt_q == CntW'(FrameLen - 1)) sum_byte_d = in_byte;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= '0;
      sum_q <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        cnt_q <= '0;
        crc_q <= '0;
        sum_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        crc_q <= crc_d;
        sum_q <= sum_d;
      end
    end
  end

  // Kept bytes and check bytes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      crc_byte_q <= crc_byte_d;
      sum_byte_q <= sum_byte_d;
      if (cnt_q < CntW'(KeepLen)) keep_q[cnt_q[KeepIdxW-1:0]] <= in_byte;
    end
  end

  // End stage: checks captured with the last byte
  frame_end_t end_q, end_d;

  always_comb begin
    end_d.short_frame = cnt_d < CntW'(FrameLen);
    end_d.crc_bad     = crc_d != crc_byte_d;
    end_d.sum_bad     = sum_d != sum_byte_d;
    end_d.strength    = s_axis_tdata[15:8];
    end_valid_d       = end_valid_q;
    if (end_adv) end_valid_d = 1'b0;
    if (in_acc && s_axis_tlast) end_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_valid_q <= 1'b0;
    end else begin
      end_valid_q <= end_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) end_q <= end_d;
  end

  // Decode of kept bytes
  logic signed [12:0] temp_wide;
  logic signed [11:0] temp;
  logic               out_of_range;
  logic [2:0]         bars;
  status_e            status;
  logic [OutDataW-1:0] result;

  always_comb begin
    temp_wide    = $signed({2'b00, keep_q[4][2:0] & TempHiMask[2:0], keep_q[5]})
                   - $signed(TempOffset);
    temp         = temp_wide[11:0];
    out_of_range = (keep_q[6] > hum_max_q) || (temp > $signed(temp_max_q));
    bars         = {keep_q[7][6], keep_q[9][7:6]};

    if (end_q.short_frame)           status = StatusShort;
    else if (keep_q[0] != type_code_q) status = StatusBadType;
    else if (end_q.crc_bad)          status = StatusBadCrc;
    else if (end_q.sum_bad)          status = StatusBadSum;
    else if (out_of_range)           status = StatusRange;
    else                             status = StatusOk;

    result = '0;
    result[2:0]    = status;
    result[102:95] = end_q.strength;
    if (status == StatusOk) begin
      result[26:3]  = {keep_q[1], keep_q[2], keep_q[3]};
      result[38:27] = temp;
      result[46:39] = keep_q[6];
      result[60:47] = {keep_q[7][5:0] & PmHiMask[5:0], keep_q[8]};
      result[74:61] = {keep_q[9][5:0] & PmHiMask[5:0], keep_q[10]};
      result[90:75] = {keep_q[11], keep_q[12]};
      result[93:91] = bars;
      result[94]    = bars <= 3'd1;
    end
  end

  // Output register
  logic [OutDataW-1:0] out_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (end_adv) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_adv) out_data_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
